// ===== rtl/bcdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bcdc_pkg;

   // six bcd digits of hh:mm:ss, tens digits only as wide as their range
   typedef struct packed {
      logic [1:0] ht;
      logic [3:0] hu;
      logic [2:0] mt;
      logic [3:0] mu;
      logic [2:0] st;
      logic [3:0] su;
   } time_type;

   // one result item
   typedef struct packed {
      time_type   digits;
      logic       editing;
      logic [1:0] sel;
      logic       pulse;
   } res_type;

   typedef enum logic [2:0] {
      KEY_ENTER  = 3'd0,
      KEY_ESCAPE = 3'd1,
      KEY_RIGHT  = 3'd2,
      KEY_UP     = 3'd3,
      KEY_DOWN   = 3'd4,
      KEY_LEFT   = 3'd5
   } key_type;

   localparam logic [1:0] FIELD_SEC  = 2'd0;
   localparam logic [1:0] FIELD_MIN  = 2'd1;
   localparam logic [1:0] FIELD_HOUR = 2'd2;

   localparam logic       FUNC_TICK = 1'b0;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TPS_ADDR = 2'd0;
   localparam logic [15:0] TPS_RESET = 16'd150;

   // increment from the chosen field upward with bcd carries
   function automatic time_type step_up(input time_type t, input logic [1:0] fld);
      time_type r;
      logic     c;
      r = t;
      c = (fld == FIELD_SEC);
      if (c) begin
         if (r.su != 4'd9) begin
            r.su = r.su + 4'd1;
            c    = 1'b0;
         end else begin
            r.su = 4'd0;
            if (r.st != 3'd5) begin
               r.st = r.st + 3'd1;
               c    = 1'b0;
            end else begin
               r.st = 3'd0;
            end
         end
      end
      c = c | (fld == FIELD_MIN);
      if (c) begin
         if (r.mu != 4'd9) begin
            r.mu = r.mu + 4'd1;
            c    = 1'b0;
         end else begin
            r.mu = 4'd0;
            if (r.mt != 3'd5) begin
               r.mt = r.mt + 3'd1;
               c    = 1'b0;
            end else begin
               r.mt = 3'd0;
            end
         end
      end
      c = c | (fld == FIELD_HOUR);
      if (c) begin
         if (r.ht == 2'd2 && r.hu == 4'd3) begin
            r.ht = 2'd0;
            r.hu = 4'd0;
         end else if (r.hu == 4'd9) begin
            r.hu = 4'd0;
            r.ht = r.ht + 2'd1;
         end else begin
            r.hu = r.hu + 4'd1;
         end
      end
      return r;
   endfunction

   // decrement from the chosen field upward with bcd borrows
   function automatic time_type step_down(input time_type t, input logic [1:0] fld);
      time_type r;
      logic     b;
      r = t;
      b = (fld == FIELD_SEC);
      if (b) begin
         if (r.su != 4'd0) begin
            r.su = r.su - 4'd1;
            b    = 1'b0;
         end else begin
            r.su = 4'd9;
            if (r.st != 3'd0) begin
               r.st = r.st - 3'd1;
               b    = 1'b0;
            end else begin
               r.st = 3'd5;
            end
         end
      end
      b = b | (fld == FIELD_MIN);
      if (b) begin
         if (r.mu != 4'd0) begin
            r.mu = r.mu - 4'd1;
            b    = 1'b0;
         end else begin
            r.mu = 4'd9;
            if (r.mt != 3'd0) begin
               r.mt = r.mt - 3'd1;
               b    = 1'b0;
            end else begin
               r.mt = 3'd5;
            end
         end
      end
      b = b | (fld == FIELD_HOUR);
      if (b) begin
         if (r.hu == 4'd0 && r.ht == 2'd0) begin
            r.hu = 4'd3;
            r.ht = 2'd2;
         end else if (r.hu == 4'd0) begin
            r.hu = 4'd9;
            r.ht = r.ht - 2'd1;
         end else begin
            r.hu = r.hu - 4'd1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bcdc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcdc_core (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic           func,
   input  wire logic [2:0]     key_code,
   input  wire logic [15:0]    tps,
   output bcdc_pkg::res_type   result
);
   import bcdc_pkg::*;

   time_type   time_ff, time_in;
   time_type   ebuf_ff, ebuf_in;
   logic       edit_ff, edit_in;
   logic [1:0] fld_ff, fld_in;
   logic [15:0] tick_ff, tick_in;
   logic       pulse;

   always_comb begin
      time_in = time_ff;
      ebuf_in = ebuf_ff;
      edit_in = edit_ff;
      fld_in  = fld_ff;
      tick_in = tick_ff;
      pulse   = 1'b0;
      if (func == FUNC_TICK) begin
         // clock and prescaler are frozen while editing
         if (!edit_ff) begin
            tick_in = tick_ff + 16'd1;
            if (tick_in == tps) begin
               tick_in = 16'd0;
               time_in = step_up(time_ff, FIELD_SEC);
               pulse   = 1'b1;
            end
         end
      end else if (!edit_ff) begin
         if (key_code == KEY_LEFT || key_code == KEY_RIGHT) begin
            ebuf_in = time_ff;
            fld_in  = FIELD_SEC;
            edit_in = 1'b1;
         end
      end else begin
         unique case (key_code)
            KEY_ENTER: begin
               time_in = ebuf_ff;
               edit_in = 1'b0;
            end
            KEY_ESCAPE: begin
               edit_in = 1'b0;
            end
            KEY_RIGHT: begin
               if (fld_ff != FIELD_SEC) fld_in = fld_ff - 2'd1;
            end
            KEY_LEFT: begin
               if (fld_ff != FIELD_HOUR) fld_in = fld_ff + 2'd1;
            end
            KEY_UP: begin
               ebuf_in = step_up(ebuf_ff, fld_ff);
            end
            KEY_DOWN: begin
               ebuf_in = step_down(ebuf_ff, fld_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         ebuf_ff <= '0;
         edit_ff <= 1'b0;
         fld_ff  <= FIELD_SEC;
         tick_ff <= 16'd0;
      end else if (accept) begin
         time_ff <= time_in;
         ebuf_ff <= ebuf_in;
         edit_ff <= edit_in;
         fld_ff  <= fld_in;
         tick_ff <= tick_in;
      end
   end

   assign result.digits  = edit_in ? ebuf_in : time_in;
   assign result.editing = edit_in;
   assign result.sel     = edit_in ? fld_in : FIELD_SEC;
   assign result.pulse   = pulse;

endmodule

`default_nettype wire

// ===== rtl/bcd_clock_with_time_set.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 24-hour bcd clock with a time-set mode. Each req item is either a timer tick
// (req_func 0) or an edge-detected key press (req_func 1, key in req_key_code).
// Every item gives exactly one rsp item with the shown digits, the edit flag,
// the selected field and a pulse that marks a one-second advance. The clock
// takes one item per cycle while the skid entry is empty: the state update is
// a single pass of bcd carry/borrow logic between the state registers and the
// result register, and its result is registered in the output buffer before
// it appears on rsp. A two-entry output buffer (result register plus skid
// register) keeps req_ready high while one result waits on rsp, so a stalled
// consumer does not block input until both entries are full. ticks_per_second
// lives at csr byte address 0 (reset 150); zero gives one advance per 65536 ticks.

module bcd_clock_with_time_set (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [2:0]  req_key_code,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_sec_units,
   output logic [2:0]       rsp_sec_tens,
   output logic [3:0]       rsp_min_units,
   output logic [2:0]       rsp_min_tens,
   output logic [3:0]       rsp_hour_units,
   output logic [1:0]       rsp_hour_tens,
   output logic             rsp_editing,
   output logic [1:0]       rsp_selected_field,
   output logic             rsp_second_pulse,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [bcdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bcdc_pkg::*;

   logic        accept;
   logic        drain;
   res_type     result;

   // csr
   logic [15:0] tps_ff;

   // output buffer: main entry drives rsp, skid catches an item during a stall
   res_type     main_ff;
   logic        main_vld_ff;
   res_type     skid_ff;
   logic        skid_vld_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_TPS_ADDR) ? {16'd0, tps_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_TPS_ADDR) begin
         tps_ff <= csr_pwdata[15:0];
      end
   end

   // ready only depends on the skid entry, never on rsp_ready
   assign req_ready = !skid_vld_ff;
   assign accept    = req_valid && req_ready;
   assign drain     = rsp_valid && rsp_ready;

   bcdc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .func     (req_func),
      .key_code (req_key_code),
      .tps      (tps_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (drain) begin
         if (skid_vld_ff) begin
            // no item is accepted while the skid entry is full
            main_ff     <= skid_ff;
            skid_vld_ff <= 1'b0;
         end else begin
            main_vld_ff <= accept;
            if (accept) main_ff <= result;
         end
      end else if (accept) begin
         if (!main_vld_ff) begin
            main_ff     <= result;
            main_vld_ff <= 1'b1;
         end else begin
            skid_ff     <= result;
            skid_vld_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid          = main_vld_ff;
   assign rsp_sec_units      = main_ff.digits.su;
   assign rsp_sec_tens       = main_ff.digits.st;
   assign rsp_min_units      = main_ff.digits.mu;
   assign rsp_min_tens       = main_ff.digits.mt;
   assign rsp_hour_units     = main_ff.digits.hu;
   assign rsp_hour_tens      = main_ff.digits.ht;
   assign rsp_editing        = main_ff.editing;
   assign rsp_selected_field = main_ff.sel;
   assign rsp_second_pulse   = main_ff.pulse;

endmodule

`default_nettype wire

// ===== rtl/bcdc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcdc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [3:0]  rsp_sec_units,
   input  wire logic [2:0]  rsp_sec_tens,
   input  wire logic [3:0]  rsp_min_units,
   input  wire logic [2:0]  rsp_min_tens,
   input  wire logic [3:0]  rsp_hour_units,
   input  wire logic [1:0]  rsp_hour_tens,
   input  wire logic        rsp_editing,
   input  wire logic [1:0]  rsp_selected_field,
   input  wire logic        rsp_second_pulse
);

   // a second advance never happens while the time is being edited
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_second_pulse |-> !rsp_editing)
      else $error("second pulse while editing");

   // field choice reads zero outside edit mode and saturates at hours inside
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_editing || rsp_selected_field == 2'd0) &&
                    rsp_selected_field != 2'd3)
      else $error("bad selected field");

   // carries and borrows keep every digit a legal time of day
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sec_units <= 4'd9 && rsp_sec_tens <= 3'd5 &&
                    rsp_min_units <= 4'd9 && rsp_min_tens <= 3'd5 &&
                    rsp_hour_units <= 4'd9 && rsp_hour_tens <= 2'd2 &&
                    (rsp_hour_tens != 2'd2 || rsp_hour_units <= 4'd3))
      else $error("illegal time digits");

   // an input item accepted into an empty output side shows up next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("result missing after accepted item");

   // a stalled result is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_second_pulse) &&
                                  $stable(rsp_editing))
      else $error("stalled result dropped");

endmodule

bind bcd_clock_with_time_set bcdc_checker u_bcdc_checker (.*);

`default_nettype wire
